FILE: rtl/sdbmt_pkg.sv
// Shared types and constants for the sdbm hashed direct-mapped table.
// No dependencies; every other file in rtl/ imports this package.
package sdbmt_pkg;

	// Default configuration
	localparam int TABLE_SIZE_DEF  = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int DATA_W  = 32;
	localparam int SLOT_W  = 12;
	localparam int BYTE_W  = 8;

	// sdbm shift amounts
	localparam int HASH_SH_A = 6;
	localparam int HASH_SH_B = 16;

	// Depth of the command queue between front and back
	localparam int Q_DEPTH = 2;

	// Operation codes
	typedef enum logic [1:0] {
		FUNC_ADD_LABEL = 2'd0,
		FUNC_ADD_SLOT  = 2'd1,
		FUNC_GET_LABEL = 2'd2,
		FUNC_GET_SLOT  = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_TAKEN = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// One classified command, ready for table access
	typedef struct packed {
		func_t              func;
		logic               oor;
		logic [SLOT_W-1:0]  slot;
		logic [DATA_W-1:0]  value;
	} cmd_t;

endpackage

FILE: rtl/sdbmt_front.sv
// Front end: accepts words, accumulates the sdbm hash, reduces it to a slot
// and pushes classified commands into the queue. Depends on sdbmt_pkg.
module sdbmt_front #(
	parameter int TABLE_SIZE = sdbmt_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sdbmt_pkg::func_t              func,
	input  logic [sdbmt_pkg::BYTE_W-1:0]  label_byte,
	input  logic [sdbmt_pkg::SLOT_W-1:0]  slot_number,
	input  logic [sdbmt_pkg::DATA_W-1:0]  item_value,
	input  logic                          clearing,
	input  logic                          q_full,
	output logic                          busy,
	output logic                          push,
	output sdbmt_pkg::cmd_t               push_data
);
	import sdbmt_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int RW = AW + 1;
	// floor(2^32 / TABLE_SIZE): quotient estimate is low by at most one
	localparam logic [DATA_W-1:0] RECIP = DATA_W'((64'd1 << DATA_W) / TABLE_SIZE);

	logic [DATA_W-1:0] hash_q;
	logic              mod_busy_q;
	logic              cnt_q;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W-1:0] qest_q;
	func_t             pend_func_q;
	logic [DATA_W-1:0] pend_val_q;

	logic                accept;
	logic                slot_op;
	logic                mod_last;
	logic                advance;
	logic                slot_push;
	logic                label_push;
	logic [2*DATA_W-1:0] prod;
	logic [RW-1:0]       step_t;
	logic [RW-1:0]       step_r;
	logic [AW-1:0]       rem_next;
	logic [DATA_W-1:0]   hash_next;
	logic                slot_oor;

	// Accept when the table is ready, no reduction runs and the queue has room
	assign busy    = clearing || mod_busy_q || q_full;
	assign accept  = start && !busy;
	assign slot_op = (func == FUNC_ADD_SLOT) || (func == FUNC_GET_SLOT);

	// First reduction step: multiply by the reciprocal to estimate the quotient
	assign prod = (2*DATA_W)'(div_q) * (2*DATA_W)'(RECIP);

	// Second reduction step: remainder from the estimate, then at most one subtract
	always_comb begin
		step_t = div_q[RW-1:0] - qest_q[RW-1:0] * RW'(TABLE_SIZE);
		if (step_t >= RW'(TABLE_SIZE)) begin
			step_r = step_t - RW'(TABLE_SIZE);
		end else begin
			step_r = step_t;
		end
		rem_next = step_r[AW-1:0];
	end

	assign mod_last   = mod_busy_q && cnt_q;
	assign advance    = mod_busy_q && !(mod_last && q_full);
	assign slot_push  = accept && slot_op;
	assign label_push = mod_last && !q_full;
	assign push       = slot_push || label_push;

	// sdbm step: byte + (h << 6) + (h << 16) - h, wrapping at 32 bits
	assign hash_next = DATA_W'(label_byte) + (hash_q << HASH_SH_A)
		+ (hash_q << HASH_SH_B) - hash_q;

	assign slot_oor = {1'b0, slot_number} >= (SLOT_W+1)'(TABLE_SIZE);

	// Build the queue word from the finished reduction or the slot operation
	always_comb begin
		if (mod_busy_q) begin
			push_data.func  = pend_func_q;
			push_data.oor   = 1'b0;
			push_data.slot  = SLOT_W'(rem_next);
			push_data.value = pend_val_q;
		end else begin
			push_data.func  = func;
			push_data.oor   = slot_oor;
			push_data.slot  = slot_number;
			push_data.value = item_value;
		end
	end

	// Hash accumulator and reduction control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= '0;
			mod_busy_q <= 1'b0;
			cnt_q      <= 1'b0;
		end else if (accept && !slot_op) begin
			if (label_byte != '0) begin
				hash_q <= hash_next;
			end else begin
				hash_q     <= '0;
				mod_busy_q <= 1'b1;
				cnt_q      <= 1'b0;
			end
		end else if (advance) begin
			cnt_q <= 1'b1;
			if (mod_last) begin
				mod_busy_q <= 1'b0;
			end
		end
	end

	// Reduction datapath and pending operation
	always_ff @(posedge clk) begin
		if (accept && !slot_op && (label_byte == '0)) begin
			div_q       <= hash_q;
			pend_func_q <= func;
			pend_val_q  <= item_value;
		end else if (mod_busy_q && !cnt_q) begin
			qest_q <= prod[2*DATA_W-1:DATA_W];
		end
	end

endmodule

FILE: rtl/sdbmt_queue.sv
// Short command queue between front end and table back end.
// Depends on sdbmt_pkg for the command word type and depth.
module sdbmt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sdbmt_pkg::cmd_t push_data,
	input  logic            pop,
	output sdbmt_pkg::cmd_t pop_data,
	output logic            full,
	output logic            empty
);
	import sdbmt_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t          ent_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = ent_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/sdbmt_back.sv
// Back end: owns the value table, clears it after reset, and runs one
// queued command as a read then a decide/write cycle. Depends on sdbmt_pkg.
module sdbmt_back #(
	parameter int TABLE_SIZE  = sdbmt_pkg::TABLE_SIZE_DEF,
	parameter int VALUE_WIDTH = sdbmt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  sdbmt_pkg::cmd_t               q_data,
	output logic                          q_pop,
	output logic                          clearing,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [sdbmt_pkg::DATA_W-1:0]  read_value,
	output logic [sdbmt_pkg::SLOT_W-1:0]  slot_used
);
	import sdbmt_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          clr_q;
	cmd_t                   cmd_q;
	logic [VALUE_WIDTH-1:0] rd_q;
	logic [VALUE_WIDTH-1:0] mem [TABLE_SIZE];

	logic                   done_q;
	status_t                status_q;
	logic [DATA_W-1:0]      read_value_q;
	logic [SLOT_W-1:0]      slot_used_q;

	logic                   we;
	logic [AW-1:0]          waddr;
	logic [VALUE_WIDTH-1:0] wdata;
	status_t                res_status;
	logic [DATA_W-1:0]      res_value;
	logic                   rd_zero;

	assign clearing = (state_q == S_CLEAR);
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign rd_zero  = (rd_q == '0);

	// Decide the result and any table write for the command in flight
	always_comb begin
		we         = 1'b0;
		waddr      = cmd_q.slot[AW-1:0];
		wdata      = VALUE_WIDTH'(cmd_q.value);
		res_status = ST_OK;
		res_value  = '0;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_EXEC) begin
			unique case (cmd_q.func)
				FUNC_ADD_LABEL: begin
					we = 1'b1;
				end
				FUNC_ADD_SLOT: begin
					if (cmd_q.oor) begin
						res_status = ST_RANGE;
					end else if (!rd_zero) begin
						res_status = ST_TAKEN;
					end else begin
						we = 1'b1;
					end
				end
				FUNC_GET_LABEL: begin
					if (rd_zero) begin
						res_status = ST_EMPTY;
					end else begin
						res_value = DATA_W'(rd_q);
					end
				end
				FUNC_GET_SLOT: begin
					if (cmd_q.oor) begin
						res_status = ST_RANGE;
					end else begin
						res_value = DATA_W'(rd_q);
					end
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	// Table write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (q_pop) begin
			rd_q <= mem[q_data.slot[AW-1:0]];
		end
	end

	// Sequencer: clear sweep, then fetch and execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Hold the fetched command and the result word
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (state_q == S_EXEC) begin
			status_q     <= res_status;
			read_value_q <= res_value;
			slot_used_q  <= cmd_q.slot;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign slot_used  = slot_used_q;

endmodule

FILE: rtl/sdbm_hashed_direct_table.sv
// Top level of the sdbm hashed direct-mapped table.
// Depends on sdbmt_pkg, sdbmt_front, sdbmt_queue and sdbmt_back.
//
//  channel  | handshake         | word
//  ---------+-------------------+---------------------------------------------
//  command  | start / busy      | func, label_byte, slot_number, item_value
//  result   | done (one cycle)  | status, read_value, slot_used
//
// A nonzero label byte is absorbed into the running hash. A terminating zero
// byte starts a hash-to-slot reduction (reciprocal multiply, then at most one
// correcting subtract) with busy held high. Each command then passes through
// the table back end as a read, then a decide and write; the result appears
// the cycle after that. The two-word queue fills and raises busy when
// commands come faster than the back end takes them. After reset the table is
// cleared one entry per cycle, all TABLE_SIZE entries, with busy held high.
// The result side cannot stall; done lasts one cycle.
module sdbm_hashed_direct_table #(
	parameter int TABLE_SIZE  = sdbmt_pkg::TABLE_SIZE_DEF,
	parameter int VALUE_WIDTH = sdbmt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [sdbmt_pkg::BYTE_W-1:0]  label_byte,
	input  logic [sdbmt_pkg::SLOT_W-1:0]  slot_number,
	input  logic [sdbmt_pkg::DATA_W-1:0]  item_value,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [sdbmt_pkg::DATA_W-1:0]  read_value,
	output logic [sdbmt_pkg::SLOT_W-1:0]  slot_used
);
	import sdbmt_pkg::*;

	logic  clearing;
	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	cmd_t  push_data;
	cmd_t  pop_data;

	sdbmt_front #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func_t'(func)),
		.label_byte  (label_byte),
		.slot_number (slot_number),
		.item_value  (item_value),
		.clearing    (clearing),
		.q_full      (q_full),
		.busy        (busy),
		.push        (push),
		.push_data   (push_data)
	);

	sdbmt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	sdbmt_back #(
		.TABLE_SIZE  (TABLE_SIZE),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (pop_data),
		.q_pop      (pop),
		.clearing   (clearing),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.slot_used  (slot_used)
	);

endmodule

FILE: sim/sdbm_hashed_direct_table_tb.sv
// Self-checking testbench for the sdbm hashed direct-mapped table.
// Depends on rtl/sdbmt_pkg.sv and rtl/sdbm_hashed_direct_table.sv; reads no files.
// A built-in table and hash predictor checks every result word on done.
module sdbm_hashed_direct_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdbmt_pkg::*;

	localparam int TBL_SIZE    = TABLE_SIZE_DEF;
	localparam int SETTLE_CYC  = 40;
	localparam int RANDOM_WORDS = 700;

	typedef struct {
		status_t            status;
		logic [DATA_W-1:0]  value;
		logic [SLOT_W-1:0]  slot;
	} table_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         func = 2'd0;
	logic [BYTE_W-1:0]  label_byte = '0;
	logic [SLOT_W-1:0]  slot_number = '0;
	logic [DATA_W-1:0]  item_value = '0;
	logic               done;
	logic [1:0]         status;
	logic [DATA_W-1:0]  read_value;
	logic [SLOT_W-1:0]  slot_used;

	// Predictor state: running hash and a shadow copy of the table
	logic [31:0]        hash_acc = '0;
	logic [DATA_W-1:0]  shadow_table [TBL_SIZE];
	logic [SLOT_W-1:0]  last_hashed_slot = '0;
	table_result_t      expected_results [$];
	table_result_t      oldest;
	int                 err_count = 0;
	bit                 no_gaps = 1'b0;

	sdbm_hashed_direct_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.label_byte  (label_byte),
		.slot_number (slot_number),
		.item_value  (item_value),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.slot_used   (slot_used)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bound the run in case the block hangs
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	// One sdbm round: h * 65599 + c, wrapping at 32 bits
	function automatic logic [31:0] sdbm_round(input logic [31:0] h, input logic [7:0] c);
		return {24'd0, c} + (h << HASH_SH_A) + (h << HASH_SH_B) - h;
	endfunction

	// Advance the shadow table for one accepted word and queue its result, if any
	task automatic predict_table_op(input func_t fn, input logic [7:0] lb,
			input logic [SLOT_W-1:0] sn, input logic [DATA_W-1:0] v);
		table_result_t r;
		logic [SLOT_W-1:0] s;
		r.status = ST_OK;
		r.value = '0;
		if (fn == FUNC_ADD_SLOT || fn == FUNC_GET_SLOT) begin
			r.slot = sn;
			if (sn >= TBL_SIZE) begin
				r.status = ST_RANGE;
			end else if (fn == FUNC_ADD_SLOT) begin
				if (shadow_table[sn] != '0)
					r.status = ST_TAKEN;
				else
					shadow_table[sn] = v;
			end else begin
				r.value = shadow_table[sn];
			end
			expected_results.push_back(r);
		end else if (lb != 8'd0) begin
			hash_acc = sdbm_round(hash_acc, lb);
		end else begin
			s = SLOT_W'(hash_acc % 32'(TBL_SIZE));
			hash_acc = '0;
			last_hashed_slot = s;
			r.slot = s;
			if (fn == FUNC_ADD_LABEL) begin
				shadow_table[s] = v;
			end else if (shadow_table[s] == '0) begin
				r.status = ST_EMPTY;
			end else begin
				r.value = shadow_table[s];
			end
			expected_results.push_back(r);
		end
	endtask

	// Drive one command word, hold it until accepted, then predict it
	task automatic send_word(input func_t fn, input logic [7:0] lb,
			input logic [SLOT_W-1:0] sn, input logic [DATA_W-1:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		label_byte <= lb;
		slot_number <= sn;
		item_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_table_op(fn, lb, sn, v);
	endtask

	// Stream a label of len bytes (byte 0 in the low bits), then the zero terminator
	task automatic send_label(input logic [47:0] lbl, input int len, input func_t end_fn,
			input logic [DATA_W-1:0] v);
		for (int i = 0; i < len; i++)
			send_word($urandom_range(0, 1) ? FUNC_ADD_LABEL : FUNC_GET_LABEL,
				lbl[8*i +: 8], SLOT_W'($urandom), $urandom);
		send_word(end_fn, 8'd0, SLOT_W'($urandom), v);
	endtask

	// Drop start and hold until every queued result has come back
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with none expected, slot", 32'(slot_used), 32'd0);
			end else begin
				oldest = expected_results.pop_front();
				if (status !== oldest.status)
					report_mismatch("status", 32'(status), 32'(oldest.status));
				if (read_value !== oldest.value)
					report_mismatch("read_value", read_value, oldest.value);
				if (slot_used !== oldest.slot)
					report_mismatch("slot_used", 32'(slot_used), 32'(oldest.slot));
			end
		end
	end

	// Empty label lands on slot 0: get flags empty, add overwrites
	task automatic test_empty_label();
		send_word(FUNC_GET_LABEL, 8'd0, 12'd0, 32'd0);
		send_word(FUNC_ADD_LABEL, 8'd0, 12'hFFF, 32'hFFFF_FFFF);
		wait_idle();
	endtask

	// Add by label, then read it back by label
	task automatic test_label_ops();
		send_label(48'h01FF, 2, FUNC_ADD_LABEL, 32'hA5A5_0001);
		send_label(48'h01FF, 2, FUNC_GET_LABEL, 32'h0);
		wait_idle();
	endtask

	// Add and get by slot: zero add, taken slot, range edges, empty get
	task automatic test_slot_ops();
		send_word(FUNC_ADD_SLOT, 8'hFF, 12'd7, 32'd0);
		send_word(FUNC_ADD_SLOT, 8'h00, 12'd7, 32'd5);
		send_word(FUNC_ADD_SLOT, 8'h80, 12'd7, 32'd6);
		send_word(FUNC_ADD_SLOT, 8'h01, 12'd1023, 32'hFFFF_FFFF);
		send_word(FUNC_ADD_SLOT, 8'h00, 12'd1024, 32'd9);
		send_word(FUNC_ADD_SLOT, 8'h00, 12'hFFF, 32'hFFFF_FFFF);
		send_word(FUNC_GET_SLOT, 8'h00, 12'd1023, 32'd0);
		send_word(FUNC_GET_SLOT, 8'h00, 12'hFFF, 32'd0);
		send_word(FUNC_GET_SLOT, 8'h00, 12'd12, 32'd0);
		wait_idle();
	endtask

	// Mix label funcs and interleave a slot op; the terminator's func decides
	task automatic test_mixed_label();
		send_word(FUNC_ADD_LABEL, 8'h41, 12'd0, 32'd0);
		send_word(FUNC_GET_SLOT, 8'h00, 12'd7, 32'd0);
		send_word(FUNC_GET_LABEL, 8'h42, 12'd0, 32'd0);
		send_word(FUNC_ADD_LABEL, 8'h00, 12'd0, 32'd77);
		send_word(FUNC_GET_LABEL, 8'h41, 12'd0, 32'd0);
		send_word(FUNC_GET_LABEL, 8'h42, 12'd0, 32'd0);
		send_word(FUNC_GET_LABEL, 8'h00, 12'd0, 32'd0);
		wait_idle();
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// Mostly well-formed labels from a small reused pool, plus slot ops and noise
	task automatic test_random();
		logic [47:0] pool_label [8];
		int pool_len [8];
		logic [47:0] fresh;
		logic [SLOT_W-1:0] sn;
		int count;
		int kind;
		int idx;
		int len;
		bit paused;
		count = 0;
		paused = 1'b0;
		for (int p = 0; p < 8; p++) begin
			pool_len[p] = $urandom_range(1, 6);
			pool_label[p] = '0;
			for (int i = 0; i < 6; i++)
				pool_label[p][8*i +: 8] = 8'($urandom_range(1, 255));
		end
		while (count < RANDOM_WORDS) begin
			// Alternate stretches with and without idle gaps
			if ($urandom_range(0, 39) == 0)
				no_gaps = ~no_gaps;
			if (!paused && count > RANDOM_WORDS / 2) begin
				wait_idle();
				paused = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				idx = $urandom_range(0, 7);
				send_label(pool_label[idx], pool_len[idx],
					$urandom_range(0, 1) ? FUNC_ADD_LABEL : FUNC_GET_LABEL, pick_value());
				count += pool_len[idx] + 1;
			end else if (kind < 55) begin
				len = $urandom_range(0, 6);
				for (int i = 0; i < 6; i++)
					fresh[8*i +: 8] = 8'($urandom_range(1, 255));
				send_label(fresh, len,
					$urandom_range(0, 1) ? FUNC_ADD_LABEL : FUNC_GET_LABEL, pick_value());
				count += len + 1;
			end else if (kind < 85) begin
				idx = $urandom_range(0, 99);
				if (idx < 30)
					sn = SLOT_W'($urandom_range(0, 15));
				else if (idx < 70)
					sn = SLOT_W'($urandom_range(0, TBL_SIZE - 1));
				else if (idx < 85)
					sn = last_hashed_slot;
				else
					sn = SLOT_W'($urandom_range(TBL_SIZE, 4095));
				send_word($urandom_range(0, 1) ? FUNC_ADD_SLOT : FUNC_GET_SLOT,
					8'($urandom), sn, pick_value());
				count++;
			end else begin
				send_word(func_t'($urandom_range(0, 3)), 8'($urandom), SLOT_W'($urandom),
					$urandom);
				count++;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		table_result_t left;
		for (int i = 0; i < TBL_SIZE; i++)
			shadow_table[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_label();
		test_label_ops();
		test_slot_ops();
		test_mixed_label();
		test_random();

		// Drain, let the back end settle, then flag anything still owed
		wait_idle();
		repeat (SETTLE_CYC) @(posedge clk);
		while (expected_results.size() != 0) begin
			left = expected_results.pop_front();
			report_mismatch("result never arrived, slot", 32'(left.slot), 32'd0);
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sdbm_hashed_direct_table.f
rtl/sdbmt_pkg.sv
rtl/sdbmt_front.sv
rtl/sdbmt_queue.sv
rtl/sdbmt_back.sv
rtl/sdbm_hashed_direct_table.sv
sim/sdbm_hashed_direct_table_tb.sv
